// File: hdl/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

   // Action carried by each request transaction
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   localparam int unsigned KEY_WIDTH     = 32;
   localparam int unsigned PAYLOAD_WIDTH = 32;
   localparam int unsigned ENTRY_WIDTH   = KEY_WIDTH + PAYLOAD_WIDTH;
   localparam int unsigned POS_WIDTH     = 7;

endpackage

// File: hdl/sorted_key_table_unit.sv
// Sorted key table: insert and lookup over key/payload pairs held in ascending key order.
//
// The table keeps up to TABLE_DEPTH key/payload pairs in one RAM, sorted by
// key. Each request is an insert or a lookup; both run a binary search for the
// lower bound on the RAM's single read port; each probe sets the address and
// then compares on the registered read data, and a last probe step finds the
// search window empty. A lookup then reads and checks the entry at the lower
// bound if that lies inside the table. An insert moves every entry from the
// lower bound up to the top one place higher, one entry per cycle through the
// read and write ports, then writes the new pair. A full table refuses the
// insert. One request is worked on at a time: req_stall is high from
// acceptance until the result is loaded into the output register. A finished
// result waits in the output register while the next request is taken.
module sorted_key_table_unit #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [skt_pkg::KEY_WIDTH-1:0]         req_key,
   input  logic [skt_pkg::PAYLOAD_WIDTH-1:0]     req_payload,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output skt_pkg::status_type                   rsp_status,
   output logic [skt_pkg::POS_WIDTH-1:0]         rsp_position,
   output logic [skt_pkg::PAYLOAD_WIDTH-1:0]     rsp_found_payload,
   output logic [skt_pkg::POS_WIDTH-1:0]         rsp_entry_count
);

   import skt_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_FULL = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_DECIDE,
      S_SHIFT,
      S_PLACE,
      S_MATCH,
      S_FINISH
   } state_type;

   state_type                state_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            lo_ff;
   logic [CW-1:0]            hi_ff;
   logic [CW-1:0]            mid_ff;
   logic [AW-1:0]            ptr_ff;
   logic                     action_ff;
   logic [KEY_WIDTH-1:0]     key_ff;
   logic [PAYLOAD_WIDTH-1:0] payload_ff;
   status_type               status_ff;
   logic [PAYLOAD_WIDTH-1:0] fpay_ff;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [POS_WIDTH-1:0]     rsp_position_ff;
   logic [PAYLOAD_WIDTH-1:0] rsp_found_payload_ff;
   logic [POS_WIDTH-1:0]     rsp_entry_count_ff;

   logic [CW-1:0]            mid_in;
   logic [CW-1:0]            last_in;
   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [ENTRY_WIDTH-1:0]   ram_wr_data;
   logic [AW-1:0]            ram_rd_addr;
   logic [ENTRY_WIDTH-1:0]   ram_rd_data;
   logic [KEY_WIDTH-1:0]     rd_key;
   logic [PAYLOAD_WIDTH-1:0] rd_payload;
   logic                     out_free;

   // Table storage: key in the upper half, payload in the lower half
   skt_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key     = ram_rd_data[ENTRY_WIDTH-1:PAYLOAD_WIDTH];
   assign rd_payload = ram_rd_data[PAYLOAD_WIDTH-1:0];

   // Midpoint of the search window and index of the top entry
   assign mid_in  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_in = count_ff - CW'(1);

   // Output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Drive RAM addresses and write data from the sequencer state
   always_comb begin
      ram_rd_addr = mid_in[AW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff + AW'(1);
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         S_PROBE: begin
            ram_rd_addr = mid_in[AW-1:0];
         end
         S_DECIDE: begin
            ram_rd_addr = (action_ff == ACTION_LOOKUP) ? lo_ff[AW-1:0] : last_in[AW-1:0];
         end
         S_SHIFT: begin
            ram_rd_addr = ptr_ff - AW'(1);
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff + AW'(1);
            ram_wr_data = ram_rd_data;
         end
         S_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff[AW-1:0];
            ram_wr_data = {key_ff, payload_ff};
         end
         default: begin
         end
      endcase
   end

   // Sequencer: search, shift or match, then hand the result over
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the held transaction once taken, unless a new one is loaded
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  action_ff  <= req_action;
                  key_ff     <= req_key;
                  payload_ff <= req_payload;
                  lo_ff      <= '0;
                  hi_ff      <= count_ff;
                  fpay_ff    <= '0;
                  state_ff   <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= S_COMPARE;
               end else begin
                  state_ff <= S_DECIDE;
               end
            end
            S_COMPARE: begin
               if (rd_key < key_ff) begin
                  lo_ff <= mid_ff + CW'(1);
               end else begin
                  hi_ff <= mid_ff;
               end
               state_ff <= S_PROBE;
            end
            S_DECIDE: begin
               if (action_ff == ACTION_LOOKUP) begin
                  if (lo_ff < count_ff) begin
                     state_ff <= S_MATCH;
                  end else begin
                     status_ff <= STATUS_NOT_FOUND;
                     state_ff  <= S_FINISH;
                  end
               end else if (count_ff == DEPTH_FULL) begin
                  status_ff <= STATUS_FULL;
                  state_ff  <= S_FINISH;
               end else if (lo_ff == count_ff) begin
                  state_ff <= S_PLACE;
               end else begin
                  ptr_ff   <= last_in[AW-1:0];
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               // advance down one entry until the lower bound has moved
               if (ptr_ff == lo_ff[AW-1:0]) begin
                  state_ff <= S_PLACE;
               end else begin
                  ptr_ff <= ptr_ff - AW'(1);
               end
            end
            S_PLACE: begin
               count_ff  <= count_ff + CW'(1);
               status_ff <= STATUS_INSERTED;
               state_ff  <= S_FINISH;
            end
            S_MATCH: begin
               if (rd_key == key_ff) begin
                  status_ff <= STATUS_FOUND;
                  fpay_ff   <= rd_payload;
               end else begin
                  status_ff <= STATUS_NOT_FOUND;
               end
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               // hold until the output register can take the transaction
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_status_ff        <= status_ff;
                  rsp_position_ff      <= POS_WIDTH'(lo_ff);
                  rsp_found_payload_ff <= fpay_ff;
                  rsp_entry_count_ff   <= POS_WIDTH'(count_ff);
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_found_payload = rsp_found_payload_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;

endmodule

// File: hdl/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: tb/tb_sorted_key_table_unit.sv
// Testbench for the sorted key table unit: random and directed inserts and lookups against a shadow table.
`timescale 1ns / 1ps

module tb_sorted_key_table_unit;
   import skt_pkg::*;

   localparam int unsigned TABLE_DEPTH   = 64;
   localparam int unsigned RANDOM_ITEMS  = 750;
   localparam int unsigned IDLE_LIMIT    = 4000;
   localparam int unsigned HOLD_OFF_LEN  = 400;
   localparam int unsigned HOLD_OFF_AT   = 150;
   localparam int unsigned SETTLE_CYCLES = 100;

   typedef struct packed {
      logic                     action;
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
      bit                       wait_for_drain;
   } table_request_type;

   typedef struct packed {
      status_type               status;
      logic [POS_WIDTH-1:0]     position;
      logic [PAYLOAD_WIDTH-1:0] found_payload;
      logic [POS_WIDTH-1:0]     entry_count;
   } table_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACTION_INSERT;
   logic [KEY_WIDTH-1:0]     req_key = '0;
   logic [PAYLOAD_WIDTH-1:0] req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   status_type               rsp_status;
   logic [POS_WIDTH-1:0]     rsp_position;
   logic [PAYLOAD_WIDTH-1:0] rsp_found_payload;
   logic [POS_WIDTH-1:0]     rsp_entry_count;

   // Shadow copy of the table contents
   logic [KEY_WIDTH-1:0]     key_shadow [TABLE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] payload_shadow [TABLE_DEPTH];
   int unsigned              table_count = 0;

   table_request_type        pending_requests [$];
   table_result_type         expected_outcomes [$];
   logic [KEY_WIDTH-1:0]     held_keys [$];

   bit                       req_fire = 1'b0;
   int unsigned              send_gap = 0;
   int unsigned              rsp_gap = 0;
   int unsigned              hold_off_left = 0;
   bit                       hold_off_done = 1'b0;
   int unsigned              results_seen = 0;
   int unsigned              mismatch_count = 0;
   int unsigned              idle_cycles = 0;
   int unsigned              cycle_number = 0;
   bit                       quiet;

   sorted_key_table_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_position      (rsp_position),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Idle-free windows so that back-to-back traffic is seen too
   assign quiet = (cycle_number[12:11] == 2'b01);

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 8);
      else
         return $urandom_range(20, 60);
   endfunction

   // Keys from the whole range, a small cluster near zero, one near the top and four around an alternating bit pattern
   function automatic logic [KEY_WIDTH-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return $urandom();
      else if (r < 70)
         return $urandom_range(0, 63);
      else if (r < 85)
         return 32'hFFFF_FFFF - $urandom_range(0, 63);
      else
         return {2'($urandom_range(0, 3)), 30'h2AAA_AAAA} ^ $urandom_range(0, 255);
   endfunction

   // Work out the result of one transaction and update the shadow table
   function automatic table_result_type compute_table_outcome(table_request_type r);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned i;
      table_result_type o;
      lo = 0;
      hi = table_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (key_shadow[mid] < r.key)
            lo = mid + 1;
         else
            hi = mid;
      end
      o.position      = POS_WIDTH'(lo);
      o.found_payload = '0;
      if (r.action == ACTION_INSERT) begin
         if (table_count >= TABLE_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            for (i = table_count; i > lo; i--) begin
               key_shadow[i]     = key_shadow[i - 1];
               payload_shadow[i] = payload_shadow[i - 1];
            end
            key_shadow[lo]     = r.key;
            payload_shadow[lo] = r.payload;
            table_count++;
            o.status = STATUS_INSERTED;
         end
      end else if (lo < table_count && key_shadow[lo] == r.key) begin
         o.status        = STATUS_FOUND;
         o.found_payload = payload_shadow[lo];
      end else begin
         o.status = STATUS_NOT_FOUND;
      end
      o.entry_count = POS_WIDTH'(table_count);
      return o;
   endfunction

   // Queue a transaction and track which keys the table will hold
   task automatic add_request(input logic action, input logic [KEY_WIDTH-1:0] key,
                              input logic [PAYLOAD_WIDTH-1:0] payload, input bit drain);
      table_request_type t;
      t.action         = action;
      t.key            = key;
      t.payload        = payload;
      t.wait_for_drain = drain;
      pending_requests.insert(pending_requests.size(), t);
      if (action == ACTION_INSERT && held_keys.size() < TABLE_DEPTH)
         held_keys.insert(held_keys.size(), key);
   endtask

   // Stimulus, reset and end of run
   initial begin
      int unsigned n;
      int unsigned sel;
      logic [KEY_WIDTH-1:0] k;
      bit drain;

      // Directed: empty table, extremes of key and payload, duplicates at both ends
      add_request(ACTION_LOOKUP, 32'd5, 32'h0, 1'b0);
      add_request(ACTION_INSERT, 32'h0, 32'h0, 1'b0);
      add_request(ACTION_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_request(ACTION_INSERT, 32'd1000, 32'hA5A5_A5A5, 1'b0);
      add_request(ACTION_INSERT, 32'd1000, 32'h5A5A_5A5A, 1'b0);
      add_request(ACTION_LOOKUP, 32'd1000, 32'h0, 1'b0);
      add_request(ACTION_LOOKUP, 32'h0, 32'h0, 1'b0);
      add_request(ACTION_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_request(ACTION_LOOKUP, 32'd999, 32'h0, 1'b0);
      add_request(ACTION_LOOKUP, 32'd1001, 32'h0, 1'b0);
      add_request(ACTION_LOOKUP, 32'hFFFF_FFFE, 32'h0, 1'b0);
      add_request(ACTION_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
      add_request(ACTION_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_request(ACTION_LOOKUP, 32'h0, 32'hFFFF_FFFF, 1'b0);
      add_request(ACTION_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b0);
      add_request(ACTION_LOOKUP, 32'h0, 32'h0, 1'b0);

      // Random: inserts until the table fills, then refused inserts; lookups mostly hit
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         drain = (n == 0) || (n == RANDOM_ITEMS / 2);
         sel   = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 30) begin
            if (held_keys.size() != 0 && sel < 25)
               k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else
               k = pick_key();
            add_request(ACTION_INSERT, k, $urandom(), drain);
         end else begin
            if (held_keys.size() != 0 && sel < 55)
               k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else if (held_keys.size() != 0 && sel < 70)
               k = held_keys[$urandom_range(0, held_keys.size() - 1)]
                   + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            else
               k = pick_key();
            add_request(ACTION_LOOKUP, k, $urandom(), drain);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last transaction to go in and every result to come back
      while (pending_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Request driver: hold a stalled transaction, otherwise advance after the gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (send_gap != 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].wait_for_drain && expected_outcomes.size() != 0)) begin
         req_action  <= pending_requests[0].action;
         req_key     <= pending_requests[0].key;
         req_payload <= pending_requests[0].payload;
         req_valid   <= 1'b1;
         void'(pending_requests.pop_front());
         send_gap <= (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response stall: one long hold-off once HOLD_OFF_AT results have been seen, random stalls otherwise
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= HOLD_OFF_LEN - 1;
         hold_off_done <= 1'b1;
      end else if (rsp_gap != 0) begin
         rsp_stall <= 1'b1;
         rsp_gap   <= rsp_gap - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         rsp_gap   <= pick_gap_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check each result against the oldest expectation, predict on acceptance
   always @(posedge clock) begin
      table_result_type e;
      table_request_type t;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_outcomes.size() == 0) begin
            $error("result transaction with no request outstanding");
            mismatch_count++;
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_position !== e.position) begin
               $error("position: expected %0d, got %0d", e.position, rsp_position);
               mismatch_count++;
            end
            if (rsp_found_payload !== e.found_payload) begin
               $error("found_payload: expected %h, got %h", e.found_payload, rsp_found_payload);
               mismatch_count++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $error("entry_count: expected %0d, got %0d", e.entry_count, rsp_entry_count);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         t.action         = req_action;
         t.key            = req_key;
         t.payload        = req_payload;
         t.wait_for_drain = 1'b0;
         expected_outcomes.insert(expected_outcomes.size(), compute_table_outcome(t));
      end
      req_fire <= !reset && req_valid && !req_stall;
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      cycle_number <= cycle_number + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
